FILE: sv/xpba_pkg.sv
// Shared types, constants and the popcount function for the XNOR-popcount
// block accumulator. No dependencies; imported by every other file but xpba_acc_mem.
`default_nettype none

package xpba_pkg;

    localparam int unsigned FRAG_ROWS_DEF = 32;
    localparam int unsigned ACC_BITS_DEF  = 16;
    localparam int unsigned THRESH_W      = 16;
    localparam int unsigned INDEX_W       = 5;
    localparam int unsigned SUM_OUT_W     = 16;
    localparam int unsigned POP_W         = 6;

    localparam logic [31:0] POP_M1 = 32'h5555_5555;
    localparam logic [31:0] POP_M2 = 32'h3333_3333;
    localparam logic [31:0] POP_M4 = 32'h0F0F_0F0F;
    localparam logic [31:0] POP_M6 = 32'h0000_003F;

    typedef struct packed {
        logic [31:0]        a_row_word;
        logic [31:0]        b_col_word;
        logic [INDEX_W-1:0] row_index;
        logic [INDEX_W-1:0] col_index;
        logic               clear_first;
        logic               store_flag;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]   out_row;
        logic [INDEX_W-1:0]   out_col;
        logic [SUM_OUT_W-1:0] acc_sum;
        logic                 sign_bit;
        logic                 bit_valid;
    } result_t;

    // Count set bits of a 32-bit word with the usual SWAR reduction.
    function automatic logic [POP_W-1:0] popcount32(input logic [31:0] x);
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [31:0] s4;
        logic [31:0] s5;
        s1 = x - ((x >> 1) & POP_M1);
        s2 = (s1 & POP_M2) + ((s1 >> 2) & POP_M2);
        s3 = (s2 + (s2 >> 4)) & POP_M4;
        s4 = s3 + (s3 >> 8);
        s5 = (s4 + (s4 >> 16)) & POP_M6;
        return s5[POP_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/xnor_popcount_block_accumulator_top.sv
// Top level of the XNOR-popcount block accumulator: input register, cell
// store, update logic and result register. Depends on xpba_pkg, xpba_acc_mem
// and xpba_update.
//
// Usage
//   Input: present an item on in_item and raise start; the transaction is
//   taken at a rising edge with start high and busy low. Each item adds
//   popcount(~(a ^ b)) to the cell (row mod FRAG_ROWS, col mod FRAG_ROWS),
//   starting from zero when clear_first is set; sums saturate.
//   Output: every item yields exactly one result transaction, shown on
//   result for a single cycle while result_valid is high. The receiver
//   cannot stall, so results are never held back or dropped.
//   Result path: an accepted item passes the input register, then the
//   result register, which drives the ports.
//   Throughput: one item per cycle while busy is low; the only loop is the
//   read-modify-write of one cell, closed by forwarding the last written
//   sum into the next item when both address the same cell.
//   Configuration: cfg_wr_en/cfg_wr_data write sign_threshold; write it
//   only while no transaction is in flight.
//   Reset: threshold returns to zero, and all FRAG_ROWS*FRAG_ROWS cells
//   (1024 by default) of the store are swept clean, one cell a cycle; busy
//   stays high during the sweep and falls for good when it ends.
`default_nettype none

module xnor_popcount_block_accumulator_top #(
    parameter int unsigned FRAG_ROWS = xpba_pkg::FRAG_ROWS_DEF,
    parameter int unsigned ACC_BITS  = xpba_pkg::ACC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire xpba_pkg::in_item_t            in_item,
    input  wire logic                          cfg_wr_en,
    input  wire logic [xpba_pkg::THRESH_W-1:0] cfg_wr_data,
    output logic                               result_valid,
    output xpba_pkg::result_t                  result
);
    import xpba_pkg::*;

    localparam int unsigned CELL_COUNT = FRAG_ROWS * FRAG_ROWS;
    localparam int unsigned IDX_W  = (FRAG_ROWS > 1) ? $clog2(FRAG_ROWS) : 1;
    localparam int unsigned CELL_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int unsigned IDX_RANGE = 1 << INDEX_W;

    // Constant wrap table: index value to index mod FRAG_ROWS.
    logic [IDX_W-1:0] wrap_tab [IDX_RANGE];

    for (genvar i = 0; i < IDX_RANGE; i++)
    begin : g_wrap
        localparam int unsigned WRAPPED = i % FRAG_ROWS;
        assign wrap_tab[i] = IDX_W'(WRAPPED);
    end

    logic                     accept;
    logic                     clearing;
    logic [CELL_W-1:0]        in_cell;

    logic                     s1_valid_reg;
    in_item_t                 s1_item_reg;
    logic [CELL_W-1:0]        s1_cell_reg;
    logic                     fwd_hit_reg;
    logic [ACC_BITS-1:0]      fwd_sum_reg;

    logic [ACC_BITS-1:0]      rd_data;
    logic [ACC_BITS-1:0]      prev_sum;
    logic [ACC_BITS-1:0]      upd_sum;
    logic [SUM_OUT_W-1:0]     upd_sum_out;
    logic                     upd_sign;

    logic [THRESH_W-1:0]      thresh_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;
    result_t                  result_next;

    assign busy    = clearing;
    assign accept  = start && !clearing;
    assign in_cell = CELL_W'(wrap_tab[in_item.row_index]) * CELL_W'(FRAG_ROWS)
                   + CELL_W'(wrap_tab[in_item.col_index]);

    // Threshold register; to be written only while idle, which the user must ensure; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            thresh_reg <= cfg_wr_data;
        end
    end

    // Valid flags of the input and result stages: both advance every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= accept;
            result_valid_reg <= s1_valid_reg;
        end
    end

    // Input stage payload, loaded on accept, and the result register. The store read
    // issued this edge misses the write of the item now in stage one, so record a hit
    // on the same cell and keep that sum for forwarding.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
            s1_cell_reg <= in_cell;
            fwd_hit_reg <= s1_valid_reg && (s1_cell_reg == in_cell);
            fwd_sum_reg <= upd_sum;
        end
        result_reg <= result_next;
    end

    xpba_acc_mem #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (CELL_W),
        .DATA_W (ACC_BITS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (s1_valid_reg),
        .wr_addr  (s1_cell_reg),
        .wr_data  (upd_sum),
        .rd_en    (accept),
        .rd_addr  (in_cell),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    assign prev_sum = fwd_hit_reg ? fwd_sum_reg : rd_data;

    xpba_update #(
        .ACC_BITS (ACC_BITS)
    ) u_update (
        .a_word      (s1_item_reg.a_row_word),
        .b_word      (s1_item_reg.b_col_word),
        .prev_sum    (prev_sum),
        .clear_first (s1_item_reg.clear_first),
        .store_flag  (s1_item_reg.store_flag),
        .threshold   (thresh_reg),
        .new_sum     (upd_sum),
        .sum_out     (upd_sum_out),
        .sign_bit    (upd_sign)
    );

    always_comb
    begin
        result_next.out_row   = s1_item_reg.row_index;
        result_next.out_col   = s1_item_reg.col_index;
        result_next.acc_sum   = upd_sum_out;
        result_next.sign_bit  = upd_sign;
        result_next.bit_valid = s1_item_reg.store_flag;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Once the sweep ends, busy never rises again.
    assert property (@(posedge clk) disable iff (!rst_n) !busy |=> !busy)
        else $error("busy rose after the clearing sweep ended");

    // An accepted transaction yields a result through the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 result_valid)
        else $error("accepted transaction produced no result");

    // No result without a transaction in stage one the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |=> !result_valid)
        else $error("result strobe without a transaction");

    // The sign bit is only ever set on a store transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sign_bit |-> result.bit_valid)
        else $error("sign bit set without store flag");

    // Nothing enters stage one during the clearing sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |=> !s1_valid_reg)
        else $error("transaction taken during clearing sweep");

endmodule

`default_nettype wire

FILE: sv/xpba_acc_mem.sv
// Accumulator cell store: one write port, one registered read port, and a
// clearing sweep after reset. Depends on nothing but its parameters.
`default_nettype none

module xpba_acc_mem #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    output logic                   clearing
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    // Sweep every cell once after reset, one per cycle.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

FILE: sv/xpba_update.sv
// Cell update: XNOR popcount, saturating add and threshold compare.
// Depends on xpba_pkg for the popcount function and field widths.
`default_nettype none

module xpba_update #(
    parameter int unsigned ACC_BITS = 16
) (
    input  wire logic [31:0]                   a_word,
    input  wire logic [31:0]                   b_word,
    input  wire logic [ACC_BITS-1:0]           prev_sum,
    input  wire logic                          clear_first,
    input  wire logic                          store_flag,
    input  wire logic [xpba_pkg::THRESH_W-1:0] threshold,
    output logic      [ACC_BITS-1:0]           new_sum,
    output logic      [xpba_pkg::SUM_OUT_W-1:0] sum_out,
    output logic                               sign_bit
);
    import xpba_pkg::*;

    localparam int unsigned CMP_W = (ACC_BITS > THRESH_W) ? ACC_BITS : THRESH_W;

    logic [POP_W-1:0]    pop;
    logic [ACC_BITS-1:0] base;
    logic [ACC_BITS:0]   wide;
    logic [CMP_W-1:0]    sum_ext;

    assign pop  = popcount32(~(a_word ^ b_word));
    assign base = clear_first ? '0 : prev_sum;
    assign wide = {1'b0, base} + (ACC_BITS + 1)'(pop);

    // Hold at the top of the range on overflow.
    assign new_sum  = wide[ACC_BITS] ? '1 : wide[ACC_BITS-1:0];
    assign sum_ext  = CMP_W'(new_sum);
    assign sum_out  = sum_ext[SUM_OUT_W-1:0];
    assign sign_bit = store_flag && (sum_ext > CMP_W'(threshold));

endmodule

`default_nettype wire

FILE: dv/xnor_popcount_block_accumulator_top_tb.sv
// Self-checking testbench for xnor_popcount_block_accumulator_top: directed transactions,
// then random accumulate sequences under several thresholds, each result checked against
// its table entry or an in-bench cell model. Depends on xpba_pkg and the top level RTL.
module xnor_popcount_block_accumulator_top_tb;
    import xpba_pkg::*;

    // Geometry and limits of the configuration under test
    localparam int unsigned GRID          = FRAG_ROWS_DEF;
    localparam int unsigned CELLS         = GRID * GRID;
    localparam logic [31:0] SUM_MAX       = (32'd1 << ACC_BITS_DEF) - 32'd1;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_ITEMS  = 1330;
    localparam int unsigned PHASES        = 7;
    localparam int unsigned REPORT_LIMIT  = 10;

    // One row of the directed table: the transaction, and optionally a hand-written result
    typedef struct packed {
        in_item_t item;
        logic     given;
        result_t  golden;
    } directed_row_t;

    localparam int unsigned DIRECTED_COUNT = 20;

    // Rows with given set carry results that follow directly from a cleared store and a
    // zero threshold; every other row is left to the cell model.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // all bits agree on an untouched cell, store set: 32 beats threshold zero
        '{'{32'h0000_0000, 32'h0000_0000, 5'd0, 5'd0, 1'b0, 1'b1}, 1'b1,
          '{5'd0, 5'd0, 16'd32, 1'b1, 1'b1}},
        // no bit agrees, corner cell, no store
        '{'{32'hFFFF_FFFF, 32'h0000_0000, 5'd31, 5'd31, 1'b0, 1'b0}, 1'b1,
          '{5'd31, 5'd31, 16'd0, 1'b0, 1'b0}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 5'd0, 1'b1, 1'b1}, 1'b1,
          '{5'd31, 5'd0, 16'd32, 1'b1, 1'b1}},
        // sum equal to threshold: not strictly greater, so the bit stays low
        '{'{32'hAAAA_AAAA, 32'h5555_5555, 5'd0, 5'd31, 1'b1, 1'b1}, 1'b1,
          '{5'd0, 5'd31, 16'd0, 1'b0, 1'b1}},
        '{'{32'h0000_0000, 32'h0000_0001, 5'd0, 5'd31, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'h0000_0000, 32'h0000_0000, 5'd0, 5'd0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{32'h0000_0000, 32'h0000_0000, 5'd0, 5'd0, 1'b0, 1'b1}, 1'b0, '0},
        // clear on a busy cell, top bit disagrees
        '{'{32'h8000_0000, 32'h0000_0000, 5'd0, 5'd0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{32'h0000_0001, 32'h0000_0000, 5'd0, 5'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'h0F0F_0F0F, 32'hF0F0_F0F0, 5'd5, 5'd17, 1'b1, 1'b0}, 1'b1,
          '{5'd5, 5'd17, 16'd0, 1'b0, 1'b0}},
        '{'{32'hFFFF_0000, 32'hFFFF_FFFF, 5'd5, 5'd17, 1'b0, 1'b1}, 1'b0, '0},
        // transposed cell must be independent of the one just written
        '{'{32'h1234_5678, 32'h1234_5678, 5'd17, 5'd5, 1'b0, 1'b1}, 1'b1,
          '{5'd17, 5'd5, 16'd32, 1'b1, 1'b1}},
        '{'{32'hDEAD_BEEF, 32'hCAFE_F00D, 5'd5, 5'd17, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'h0000_FFFF, 32'h00FF_00FF, 5'd17, 5'd5, 1'b0, 1'b1}, 1'b0, '0},
        '{'{32'h3333_3333, 32'h3333_3333, 5'd5, 5'd17, 1'b1, 1'b1}, 1'b0, '0},
        // consecutive rows on one cell exercise the forwarding path when no idle gap falls between
        '{'{32'h7FFF_FFFE, 32'h0000_0001, 5'd9, 5'd9, 1'b1, 1'b0}, 1'b0, '0},
        '{'{32'h5555_5555, 32'h5555_AAAA, 5'd9, 5'd9, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd9, 5'd9, 1'b0, 1'b1}, 1'b0, '0},
        '{'{32'h0000_0000, 32'hFFFF_FFFF, 5'd31, 5'd31, 1'b1, 1'b1}, 1'b1,
          '{5'd31, 5'd31, 16'd0, 1'b0, 1'b1}},
        // store flag clear: the bit is forced low even though the sum beats the threshold
        '{'{32'hA5A5_A5A5, 32'hA5A5_A5A5, 5'd31, 5'd31, 1'b1, 1'b0}, 1'b1,
          '{5'd31, 5'd31, 16'd32, 1'b0, 1'b0}}
    };

    // DUT inputs, all known from time zero
    logic     clk         = 1'b0;
    logic     rst_n       = 1'b0;
    logic     start       = 1'b0;
    in_item_t in_item     = '0;
    logic     cfg_wr_en   = 1'b0;
    logic [THRESH_W-1:0] cfg_wr_data = '0;

    logic     busy;
    logic     result_valid;
    result_t  result;

    // Hand-written expectation travelling alongside the transaction on in_item
    logic     golden_given  = 1'b0;
    result_t  golden_result = '0;

    // Cell model and its view of the threshold register
    logic [ACC_BITS_DEF-1:0] cell_sums [CELLS];
    logic [THRESH_W-1:0]     threshold_model;
    result_t                 expected_results [$];
    int unsigned             error_count = 0;
    int unsigned             cycle_count = 0;

    xnor_popcount_block_accumulator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_item      (in_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count the bit positions where the two words agree
    function automatic logic [31:0] agree_count(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] n;
        n = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (a[i] == b[i])
                n = n + 32'd1;
        end
        return n;
    endfunction

    // Apply one transaction to the cell model and return the result it must produce
    function automatic result_t accumulate_cell(input in_item_t it);
        int unsigned idx;
        logic [31:0] total;
        result_t     r;
        idx   = (int'(it.row_index) % GRID) * GRID + (int'(it.col_index) % GRID);
        total = it.clear_first ? 32'd0 : 32'(cell_sums[idx]);
        total = total + agree_count(it.a_row_word, it.b_col_word);
        // saturate rather than wrap
        if (total > SUM_MAX)
            total = SUM_MAX;
        cell_sums[idx] = total[ACC_BITS_DEF-1:0];
        r.out_row   = it.row_index;
        r.out_col   = it.col_index;
        r.acc_sum   = total[SUM_OUT_W-1:0];
        r.sign_bit  = it.store_flag && (total > 32'(threshold_model));
        r.bit_valid = it.store_flag;
        return r;
    endfunction

    function automatic in_item_t random_fields();
        in_item_t it;
        it.a_row_word  = $urandom;
        it.b_col_word  = $urandom;
        it.row_index   = INDEX_W'($urandom_range(0, GRID - 1));
        it.col_index   = INDEX_W'($urandom_range(0, GRID - 1));
        it.clear_first = 1'($urandom_range(0, 1));
        it.store_flag  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Check results against the oldest expectation, then log any transaction taken at
    // this edge. Both read pre-edge values, so the order against the driver is immaterial.
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        result_t predicted;
        if (rst_n)
        begin
            if (result_valid === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected result: row %0d col %0d sum %0d sign %b valid %b",
                                 result.out_row, result.out_col, result.acc_sum,
                                 result.sign_bit, result.bit_valid);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.out_row !== want.out_row || result.out_col !== want.out_col ||
                        result.acc_sum !== want.acc_sum || result.sign_bit !== want.sign_bit ||
                        result.bit_valid !== want.bit_valid)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display({"mismatch: expected row %0d col %0d sum %0d sign %b ",
                                      "valid %b, got row %0d col %0d sum %0d sign %b valid %b"},
                                     want.out_row, want.out_col, want.acc_sum, want.sign_bit,
                                     want.bit_valid, result.out_row, result.out_col,
                                     result.acc_sum, result.sign_bit, result.bit_valid);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                // keep the model in step even where the table gives the answer
                predicted = accumulate_cell(in_item);
                expected_results.push_back(golden_given ? golden_result : predicted);
            end
        end
    end

    // Offer one transaction, hold it until taken, then, if idle_on, idle for a random gap that may be zero
    task automatic send_item(input in_item_t it, input logic given, input result_t golden,
                             input bit idle_on);
        int unsigned gap;
        int unsigned roll;
        start         <= 1'b1;
        in_item       <= it;
        golden_given  <= given;
        golden_result <= golden;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        gap = 0;
        if (idle_on)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 92)
                gap = $urandom_range(8, 40);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            // drop start and scribble on the payload, which must be ignored
            start   <= 1'b0;
            in_item <= random_fields();
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait for every outstanding result, plus the pipeline tail
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en       <= 1'b0;
        threshold_model = value;
    endtask

    // Mostly well-formed dot-product sequences, half on a few hot cells, with some noise and
    // some sequences that skip the clear or store early
    task automatic run_sequences(input int unsigned count, input bit idle_on);
        int unsigned sent;
        int unsigned len;
        in_item_t    it;
        logic [4:0]  row;
        logic [4:0]  col;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(random_fields(), 1'b0, '0, idle_on);
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    row = 5'($urandom_range(0, 3));
                    col = 5'($urandom_range(28, 31));
                end
                else
                begin
                    row = 5'($urandom_range(0, GRID - 1));
                    col = 5'($urandom_range(0, GRID - 1));
                end
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                begin
                    it.a_row_word = $urandom;
                    case ($urandom_range(0, 3))
                        0: it.b_col_word = $urandom;
                        1: it.b_col_word = it.a_row_word ^ ($urandom & $urandom & $urandom);
                        2: it.b_col_word = ~it.a_row_word ^ ($urandom & $urandom);
                        default: it.b_col_word = it.a_row_word;
                    endcase
                    it.row_index   = row;
                    it.col_index   = col;
                    it.clear_first = (k == 0) ? ($urandom_range(0, 7) != 0) : 1'b0;
                    it.store_flag  = (k == len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0);
                    send_item(it, 1'b0, '0, idle_on);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence: reset, wait out the store sweep, directed table, then threshold
    // phases separated by a full drain.
    initial
    begin : stimulus
        logic [THRESH_W-1:0] thresholds [PHASES];
        bit                  idle_on;
        foreach (cell_sums[i])
            cell_sums[i] = '0;
        threshold_model = '0;
        thresholds[0] = 16'h0000;
        thresholds[1] = 16'd48;
        thresholds[2] = 16'hFFFF;
        thresholds[3] = 16'd120;
        thresholds[4] = THRESH_W'($urandom_range(0, 255));
        thresholds[5] = THRESH_W'($urandom);
        thresholds[6] = 16'd1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // hold off until the clearing sweep releases busy
        do
            @(posedge clk);
        while (busy !== 1'b0);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].given, DIRECTED_ROWS[i].golden,
                      1'b1);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_threshold(thresholds[p]);
            // leave some phases free of gaps entirely
            idle_on = ($urandom_range(0, 3) != 0);
            run_sequences(RANDOM_ITEMS / PHASES, idle_on);
            settle();
        end

        if (error_count == 0)
            $display("xnor_popcount_block_accumulator_top_tb: PASS");
        else
            $display("xnor_popcount_block_accumulator_top_tb: FAIL");
        $finish;
    end

    // End a hung run after a generous number of cycles
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("xnor_popcount_block_accumulator_top_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/xpba_pkg.sv
sv/xpba_acc_mem.sv
sv/xpba_update.sv
sv/xnor_popcount_block_accumulator_top.sv
dv/xnor_popcount_block_accumulator_top_tb.sv
